// File: src/column_quantize_bit_packer_macros.svh
// assertion macros shared by the quantizer and packer modules
`ifndef COLUMN_QUANTIZE_BIT_PACKER_MACROS_SVH
`define COLUMN_QUANTIZE_BIT_PACKER_MACROS_SVH

// plain property, checked at every clock edge outside reset
`define CQBP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// same-cycle implication
`define CQBP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

// File: src/cqbp_pkg.sv
// shared constants, state type and control structs of the quantizer and packer
package cqbp_pkg;

  localparam int unsigned ValueWidth    = 32;
  localparam int unsigned MaxColumnBits = 61;
  localparam int unsigned BitsWidth     = 6;
  localparam int unsigned MaxAbsWidth   = 31;
  localparam int unsigned QuoWidth      = 63;
  localparam int unsigned CodeWidth     = 64;
  localparam int unsigned ProdWidth     = ValueWidth + QuoWidth;
  localparam int unsigned ByteWidth     = 8;
  localparam int unsigned StreamWidth   = CodeWidth + ByteWidth;
  localparam int unsigned FillWidth     = 3;
  localparam int unsigned CntWidth      = 4;
  localparam int unsigned TotalWidth    = 7;
  localparam int unsigned InTdataWidth  = 40;
  localparam int unsigned OutTuserWidth = 2;
  localparam int unsigned MaxBytes      = 8;

  // tuser bit positions on the result side
  localparam int unsigned UserValidBit = 0;
  localparam int unsigned UserEosBit   = 1;

  localparam logic [BitsWidth-1:0]   QExtra     = BitsWidth'(2);
  localparam logic [MaxAbsWidth-1:0] MaxAbsInit = MaxAbsWidth'(1 << 30);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_DIV,
    ST_ROUND,
    ST_EMIT,
    ST_FLUSH
  } cqbp_state_e;

  typedef struct packed {
    logic load;
    logic prep;
    logic div_step;
    logic pack;
    logic emit;
    logic flush;
  } cqbp_cmd_t;

  typedef struct packed {
    logic skip;
    logic eom;
    logic sat;
    logic div_last;
    logic bytes_left;
    logic last_byte;
    logic out_free;
  } cqbp_status_t;

endpackage

// File: src/cqbp_dpath.sv
// datapath: magnitude capture, restoring divider, rounding, bit packer, output beat
`include "column_quantize_bit_packer_macros.svh"

module cqbp_dpath (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     cfg_we_i,
  input  logic [cqbp_pkg::MaxAbsWidth-1:0]         cfg_wdata_i,
  input  logic signed [cqbp_pkg::ValueWidth-1:0]   sample_value_i,
  input  logic [cqbp_pkg::BitsWidth-1:0]           column_bits_i,
  input  logic                                     end_of_matrix_i,
  input  cqbp_pkg::cqbp_cmd_t                      cmd_i,
  output cqbp_pkg::cqbp_status_t                   status_o,
  output logic                                     out_valid_o,
  input  logic                                     out_ready_i,
  output logic [cqbp_pkg::ByteWidth-1:0]           out_byte_o,
  output logic                                     out_bvalid_o,
  output logic                                     out_last_o,
  output logic                                     out_eos_o
);
  import cqbp_pkg::*;

  // configuration and captured element
  logic [MaxAbsWidth-1:0] max_abs_q;
  logic                   neg_q, eom_q, skip_q, sat_q;
  logic [ValueWidth-1:0]  mag_q;
  logic [BitsWidth-1:0]   qbits_q;

  // divider state
  logic [MaxAbsWidth-1:0] rem_q, rem_d;
  logic [QuoWidth-1:0]    shift_q;
  logic [QuoWidth-1:0]    quo_q, quo_d;
  logic [BitsWidth-1:0]   cnt_q;

  // packer state
  logic [StreamWidth-1:0] stream_q, stream_d;
  logic [FillWidth-1:0]   fill_q, fill_d;
  logic [CntWidth-1:0]    byte_cnt_q, byte_cnt_d;

  // output beat register
  logic                 out_valid_q;
  logic [ByteWidth-1:0] out_byte_q;
  logic                 out_bvalid_q, out_last_q, out_eos_q;

  logic [ValueWidth-1:0]  v_u, mag_in;
  logic                   neg_in;
  logic [BitsWidth-1:0]   bits_sat, lshift;
  logic [ProdWidth-1:0]   prod;
  logic                   sat_d;
  logic [MaxAbsWidth:0]   trial, divisor, diff;
  logic                   ge, round_up;
  logic [CodeWidth-1:0]   top, mag_code, code, aligned;
  logic [StreamWidth-1:0] merged;
  logic [TotalWidth-1:0]  total;
  logic                   out_free;

  // element capture: cap bit count, take magnitude
  always_comb begin
    v_u      = sample_value_i;
    neg_in   = v_u[ValueWidth-1];
    mag_in   = neg_in ? (~v_u + ValueWidth'(1)) : v_u;
    bits_sat = (column_bits_i > BitsWidth'(MaxColumnBits)) ? BitsWidth'(MaxColumnBits)
                                                           : column_bits_i;
  end

  // scaled numerator mag * (2^q - 1), aligned so the quotient has q bits
  always_comb begin
    lshift  = BitsWidth'(QuoWidth) - qbits_q;
    prod    = {mag_q, QuoWidth'(0)} - (ProdWidth'(mag_q) << lshift);
    sat_d   = mag_q >= {1'b0, max_abs_q};
    divisor = {1'b0, max_abs_q};
  end

  // one restoring division step
  always_comb begin
    trial = {rem_q, shift_q[QuoWidth-1]};
    ge    = trial >= divisor;
    diff  = trial - divisor;
    rem_d = ge ? diff[MaxAbsWidth-1:0] : trial[MaxAbsWidth-1:0];
    quo_d = {quo_q[QuoWidth-2:0], ge};
  end

  // rounding, sign insertion and merge with pending bits
  always_comb begin
    round_up = {rem_q, 1'b0} >= divisor;
    top      = (CodeWidth'(1) << qbits_q) - CodeWidth'(1);
    mag_code = sat_q ? top : ({1'b0, quo_q} + CodeWidth'(round_up));
    code     = mag_code | (CodeWidth'(neg_q) << qbits_q);
    aligned  = code << lshift;
    merged   = {stream_q[StreamWidth-1 -: ByteWidth], CodeWidth'(0)}
             | ({aligned, ByteWidth'(0)} >> fill_q);
    total    = TotalWidth'(fill_q) + TotalWidth'(qbits_q) + TotalWidth'(1);
  end

  // packer next state
  always_comb begin
    stream_d   = stream_q;
    fill_d     = fill_q;
    byte_cnt_d = byte_cnt_q;
    if (cmd_i.pack) begin
      stream_d   = merged;
      fill_d     = total[FillWidth-1:0];
      byte_cnt_d = total[TotalWidth-1:FillWidth];
    end else if (cmd_i.emit) begin
      stream_d   = stream_q << ByteWidth;
      byte_cnt_d = byte_cnt_q - CntWidth'(1);
    end else if (cmd_i.flush) begin
      stream_d = '0;
      fill_d   = '0;
    end
  end

  assign out_free = !out_valid_q || out_ready_i;

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_abs_q   <= MaxAbsInit;
      stream_q    <= '0;
      fill_q      <= '0;
      byte_cnt_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        max_abs_q <= cfg_wdata_i;
      end
      stream_q   <= stream_d;
      fill_q     <= fill_d;
      byte_cnt_q <= byte_cnt_d;
      if (cmd_i.emit || cmd_i.flush) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      neg_q   <= neg_in;
      mag_q   <= mag_in;
      qbits_q <= bits_sat + QExtra;
      skip_q  <= bits_sat == '0;
      eom_q   <= end_of_matrix_i;
    end
    if (cmd_i.prep) begin
      sat_q   <= sat_d;
      rem_q   <= prod[QuoWidth +: MaxAbsWidth];
      shift_q <= prod[QuoWidth-1:0];
      quo_q   <= '0;
      cnt_q   <= qbits_q;
    end else if (cmd_i.div_step) begin
      rem_q   <= rem_d;
      quo_q   <= quo_d;
      shift_q <= {shift_q[QuoWidth-2:0], 1'b0};
      cnt_q   <= cnt_q - BitsWidth'(1);
    end
    if (cmd_i.emit) begin
      out_byte_q   <= stream_q[StreamWidth-1 -: ByteWidth];
      out_bvalid_q <= 1'b1;
      out_last_q   <= (byte_cnt_q == CntWidth'(1)) && !eom_q;
      out_eos_q    <= 1'b0;
    end else if (cmd_i.flush) begin
      out_byte_q   <= stream_q[StreamWidth-1 -: ByteWidth];
      out_bvalid_q <= fill_q != '0;
      out_last_q   <= 1'b1;
      out_eos_q    <= 1'b1;
    end
  end

  // status toward the controller
  always_comb begin
    status_o.skip       = skip_q;
    status_o.eom        = eom_q;
    status_o.sat        = sat_q;
    status_o.div_last   = cnt_q == BitsWidth'(1);
    status_o.bytes_left = byte_cnt_q != '0;
    status_o.last_byte  = byte_cnt_q == CntWidth'(1);
    status_o.out_free   = out_free;
  end

  assign out_valid_o  = out_valid_q;
  assign out_byte_o   = out_byte_q;
  assign out_bvalid_o = out_bvalid_q;
  assign out_last_o   = out_last_q;
  assign out_eos_o    = out_eos_q;

  // partial remainder stays below the divisor during division
  `CQBP_ASSERT_IMP(a_rem_below_div, cmd_i.div_step, rem_q < max_abs_q, "remainder out of range")
  // one element never yields more than eight full bytes
  `CQBP_ASSERT(a_byte_cnt_max, byte_cnt_q <= CntWidth'(MaxBytes), "byte count overflow")

endmodule

// File: src/cqbp_ctrl.sv
// controller state machine: sequences capture, division, packing and beat output
`include "column_quantize_bit_packer_macros.svh"

module cqbp_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  cqbp_pkg::cqbp_status_t status_i,
  output cqbp_pkg::cqbp_cmd_t    cmd_o
);
  import cqbp_pkg::*;

  cqbp_state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_PREP;
      end
      ST_PREP: begin
        if (status_i.skip) begin
          state_d = status_i.eom ? ST_FLUSH : ST_IDLE;
        end else begin
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (status_i.sat || status_i.div_last) state_d = ST_ROUND;
      end
      ST_ROUND: begin
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (!status_i.bytes_left || (status_i.out_free && status_i.last_byte)) begin
          state_d = status_i.eom ? ST_FLUSH : ST_IDLE;
        end
      end
      ST_FLUSH: begin
        if (status_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_PREP: begin
        cmd_o.prep = !status_i.skip;
      end
      ST_DIV: begin
        cmd_o.div_step = !status_i.sat;
      end
      ST_ROUND: begin
        cmd_o.pack = 1'b1;
      end
      ST_EMIT: begin
        cmd_o.emit = status_i.bytes_left && status_i.out_free;
      end
      ST_FLUSH: begin
        cmd_o.flush = status_i.out_free;
      end
      default: cmd_o = '0;
    endcase
  end

  // at most one datapath command per cycle
  `CQBP_ASSERT(a_cmd_onehot, $onehot0(cmd_o), "conflicting datapath commands")
  // a beat is only pushed into a free output register
  `CQBP_ASSERT_IMP(a_push_free, cmd_o.emit || cmd_o.flush, status_i.out_free, "push while stalled")

endmodule

// File: src/column_quantize_bit_packer.sv
// top level of the column quantizer and MSB-first bit packer
// Each element beat is quantized to q = min(column_bits, 61) + 2 magnitude bits plus a sign bit
// (round half away from zero of |v| * (2^q - 1) / max_abs, saturating) and packed
// MSB first into bytes. One element is handled at a time: it passes through capture,
// prep, the restoring divider that resolves one quotient bit per cycle, rounding and
// one output beat per emitted byte (at most eight); an element at or above max_abs
// takes no division step and saturates, and an element with zero column bits is
// skipped. The end of matrix beat (s_axis_tlast_i) adds one flush beat: the
// pending partial byte, or a marker beat with byte_valid low when nothing is pending.
// max_abs is written through cfg_we_i / cfg_wdata_i; the user must write it only while
// the block is idle, the block itself leaves this to the user. It resets to 1.0 in Q1.30.
module column_quantize_bit_packer (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [cqbp_pkg::MaxAbsWidth-1:0]       cfg_wdata_i,
  input  logic                                   s_axis_tvalid_i,
  output logic                                   s_axis_tready_o,
  // sample_value [31:0], column_bits [37:32], zero pad [39:38]
  input  logic [cqbp_pkg::InTdataWidth-1:0]      s_axis_tdata_i,
  input  logic                                   s_axis_tlast_i,
  output logic                                   m_axis_tvalid_o,
  input  logic                                   m_axis_tready_i,
  // packed_byte [7:0]
  output logic [cqbp_pkg::ByteWidth-1:0]         m_axis_tdata_o,
  // byte_valid [0], end_of_stream [1]
  output logic [cqbp_pkg::OutTuserWidth-1:0]     m_axis_tuser_o,
  output logic                                   m_axis_tlast_o
);
  import cqbp_pkg::*;

  cqbp_cmd_t                     cmd;
  cqbp_status_t                  status;
  logic signed [ValueWidth-1:0]  sample_value;
  logic [BitsWidth-1:0]          column_bits;
  logic                          bvalid, eos;

  // unpack the input beat
  assign sample_value = $signed(s_axis_tdata_i[ValueWidth-1:0]);
  assign column_bits  = s_axis_tdata_i[ValueWidth +: BitsWidth];

  cqbp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  cqbp_dpath u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .sample_value_i  (sample_value),
    .column_bits_i   (column_bits),
    .end_of_matrix_i (s_axis_tlast_i),
    .cmd_i           (cmd),
    .status_o        (status),
    .out_valid_o     (m_axis_tvalid_o),
    .out_ready_i     (m_axis_tready_i),
    .out_byte_o      (m_axis_tdata_o),
    .out_bvalid_o    (bvalid),
    .out_last_o      (m_axis_tlast_o),
    .out_eos_o       (eos)
  );

  // pack the result flags
  always_comb begin
    m_axis_tuser_o               = '0;
    m_axis_tuser_o[UserValidBit] = bvalid;
    m_axis_tuser_o[UserEosBit]   = eos;
  end

endmodule

// File: tb/column_quantize_bit_packer_test.sv
// testbench of the column quantizer and bit packer: predicted byte stream vs stream beats
`timescale 1ns / 100ps

module column_quantize_bit_packer_test;

  localparam int unsigned ClkHalf      = 4;
  localparam int unsigned ResetCycles  = 10;
  localparam int unsigned SettleCycles = 100;
  localparam int unsigned LongHold     = 400;
  localparam int unsigned QuietLimit   = 5000;
  localparam int unsigned PhaseItems   = 23;
  localparam logic [30:0] MaxAbsTop    = 31'h7fff_ffff;
  localparam logic [30:0] MaxAbsOne    = 31'h4000_0000;

  typedef struct packed {
    logic [31:0] value;
    logic [5:0]  bits;
    logic        eom;
  } element_t;

  typedef struct packed {
    logic [7:0] data;
    logic       valid;
    logic       run_end;
    logic       eos;
  } out_beat_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [cqbp_pkg::MaxAbsWidth-1:0] cfg_wdata_i = '0;
  logic s_axis_tvalid_i = 1'b0;
  logic s_axis_tready_o;
  // sample_value [31:0], column_bits [37:32], zero pad [39:38]
  logic [cqbp_pkg::InTdataWidth-1:0] s_axis_tdata_i = '0;
  logic s_axis_tlast_i = 1'b0;
  logic m_axis_tvalid_o;
  logic m_axis_tready_i = 1'b0;
  // packed_byte [7:0]
  logic [cqbp_pkg::ByteWidth-1:0] m_axis_tdata_o;
  // byte_valid [0], end_of_stream [1]
  logic [cqbp_pkg::OutTuserWidth-1:0] m_axis_tuser_o;
  logic m_axis_tlast_o;

  // predictor state: configured divisor, partial byte and its fill position
  logic [30:0] pack_max_abs = MaxAbsOne;
  logic [7:0]  pack_acc = 8'd0;
  int          pack_pos = 7;

  element_t  elements_to_send[$];
  out_beat_t packed_bytes_due[$];
  int unsigned mismatch_count = 0;

  // sender and receiver bookkeeping
  element_t    tx_item;
  bit          tx_busy = 1'b0;
  bit          tx_burst = 1'b0;
  bit          element_taken = 1'b0;
  int unsigned tx_gap = 0;
  bit          rx_burst = 1'b0;
  bit          result_taken = 1'b0;
  bit          hold_req = 1'b0;
  int unsigned rx_wait = 0;
  int unsigned rx_hold = 0;
  int unsigned quiet_cycles = 0;

  column_quantize_bit_packer i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  always #(ClkHalf) clk_i = ~clk_i;

  // quantize one element, pack its bits and queue the bytes it completes
  task automatic quantize_and_pack(input element_t el);
    logic [5:0]   bits;
    int unsigned  q;
    int           j;
    logic [31:0]  mag;
    logic [63:0]  top;
    logic [63:0]  code;
    logic [127:0] numer;
    out_beat_t    beat;
    out_beat_t    run_beats[$];
    begin
      bits = (el.bits > cqbp_pkg::MaxColumnBits) ? 6'(cqbp_pkg::MaxColumnBits) : el.bits;
      if (bits != 0) begin
        q = bits + 2;
        top = (64'd1 << q) - 64'd1;
        mag = el.value[31] ? (~el.value + 32'd1) : el.value;
        // saturate at or above the divisor, else round half away from zero
        if (64'(mag) >= 64'(pack_max_abs)) begin
          code = top;
        end else begin
          numer = 128'(mag) * 128'(top) * 128'd2 + 128'(pack_max_abs);
          code = 64'(numer / (128'(pack_max_abs) * 128'd2));
          if (code > top) code = top;
        end
        code = code | (64'(el.value[31]) << q);
        // msb first into the partial byte
        for (j = int'(q); j >= 0; j--) begin
          pack_acc[pack_pos] = code[j];
          if (pack_pos == 0) begin
            beat = '{pack_acc, 1'b1, 1'b0, 1'b0};
            run_beats = {run_beats, beat};
            pack_acc = 8'd0;
            pack_pos = 7;
          end else begin
            pack_pos--;
          end
        end
      end
      // end of matrix: flush the partial byte or send the empty marker
      if (el.eom) begin
        if (pack_pos < 7) beat = '{pack_acc, 1'b1, 1'b0, 1'b1};
        else beat = '{8'd0, 1'b0, 1'b0, 1'b1};
        run_beats = {run_beats, beat};
        pack_acc = 8'd0;
        pack_pos = 7;
      end
      foreach (run_beats[k]) begin
        beat = run_beats[k];
        beat.run_end = (k == run_beats.size() - 1);
        packed_bytes_due = {packed_bytes_due, beat};
      end
    end
  endtask

  task automatic add_element(input logic [31:0] value, input logic [5:0] bits,
                             input logic eom);
    element_t el;
    begin
      el = '{value, bits, eom};
      elements_to_send = {elements_to_send, el};
    end
  endtask

  function automatic logic [5:0] pick_bits();
    int unsigned r;
    begin
      r = $urandom_range(0, 99);
      if (r < 10) return 6'd0;
      if (r < 80) return 6'($urandom_range(1, 12));
      if (r < 95) return 6'($urandom_range(13, 61));
      return 6'($urandom_range(62, 63));
    end
  endfunction

  // magnitudes mostly below the divisor so that rounding is exercised
  function automatic logic [31:0] pick_value();
    int unsigned r;
    logic [31:0] mag;
    begin
      r = $urandom_range(0, 99);
      if (r < 45) mag = $urandom_range(0, 32'(pack_max_abs));
      else if (r < 60) mag = 32'(pack_max_abs) - 32'($urandom_range(0, 1));
      else if (r < 75) mag = $urandom_range(0, 255);
      else return $urandom;
      return $urandom_range(0, 1) ? (~mag + 32'd1) : mag;
    end
  endfunction

  // whole matrices with random content, some stray elements in between
  task automatic queue_random_matrices(input int unsigned n_items);
    int unsigned counted;
    int unsigned len;
    int unsigned k;
    logic [5:0]  bits;
    logic        eom;
    begin
      @(posedge clk_i);
      counted = 0;
      while (counted < n_items) begin
        if ($urandom_range(0, 9) == 0) begin
          bits = 6'($urandom_range(0, 63));
          eom = 1'($urandom_range(0, 1));
          add_element($urandom, bits, eom);
          counted++;
        end else begin
          len = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 12) : $urandom_range(1, 5);
          for (k = 0; k < len; k++) begin
            bits = pick_bits();
            eom = (k == len - 1);
            add_element(pick_value(), bits, eom);
            counted++;
          end
        end
      end
    end
  endtask

  // register write while the block is idle
  task automatic write_max_abs(input logic [30:0] value);
    begin
      cfg_we_i <= 1'b1;
      cfg_wdata_i <= value;
      @(negedge clk_i);
      cfg_we_i <= 1'b0;
      pack_max_abs = value;
    end
  endtask

  // all elements sent, all bytes received, then let a silent element finish
  task automatic wait_idle();
    begin
      while (elements_to_send.size() != 0 || tx_busy || packed_bytes_due.size() != 0)
        @(negedge clk_i);
      repeat (SettleCycles) @(negedge clk_i);
    end
  endtask

  // element sender
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (element_taken) begin
        element_taken = 1'b0;
        tx_busy = 1'b0;
        if ($urandom_range(0, 15) == 0) tx_burst = !tx_burst;
        tx_gap = tx_burst ? 0 : $urandom_range(0, 15);
      end
      if (!tx_busy) begin
        if (tx_gap != 0) begin
          tx_gap--;
        end else if (elements_to_send.size() != 0) begin
          tx_item = elements_to_send.pop_front();
          tx_busy = 1'b1;
          s_axis_tdata_i <= cqbp_pkg::InTdataWidth'({tx_item.bits, tx_item.value});
          s_axis_tlast_i <= tx_item.eom;
        end
      end
      s_axis_tvalid_i <= tx_busy;
    end
  end

  // element beat accepted: predict its bytes
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid_i && s_axis_tready_o) begin
      quantize_and_pack(tx_item);
      element_taken = 1'b1;
    end
  end

  // byte receiver with random stalls and the long hold-off
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_req) begin
        rx_hold = LongHold;
        hold_req = 1'b0;
      end
      if (result_taken) begin
        result_taken = 1'b0;
        if ($urandom_range(0, 15) == 0) rx_burst = !rx_burst;
        rx_wait = rx_burst ? 0 : $urandom_range(0, 15);
      end
      if (rx_hold != 0) begin
        rx_hold--;
        m_axis_tready_i <= 1'b0;
      end else if (rx_wait != 0) begin
        rx_wait--;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= 1'b1;
      end
    end
  end

  // byte beat check against the oldest prediction
  always @(posedge clk_i) begin
    out_beat_t got;
    out_beat_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      result_taken = 1'b1;
      got = '{m_axis_tdata_o, m_axis_tuser_o[cqbp_pkg::UserValidBit], m_axis_tlast_o,
              m_axis_tuser_o[cqbp_pkg::UserEosBit]};
      if (packed_bytes_due.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected beat, expected none, actual byte %02h valid %b last %b eos %b",
                 $time, got.data, got.valid, got.run_end, got.eos);
      end else begin
        want = packed_bytes_due.pop_front();
        if (got.data !== want.data) begin
          mismatch_count++;
          $display("%0t: packed_byte expected %02h actual %02h", $time, want.data, got.data);
        end
        if (got.valid !== want.valid) begin
          mismatch_count++;
          $display("%0t: byte_valid expected %b actual %b", $time, want.valid, got.valid);
        end
        if (got.run_end !== want.run_end) begin
          mismatch_count++;
          $display("%0t: last_of_run expected %b actual %b", $time, want.run_end, got.run_end);
        end
        if (got.eos !== want.eos) begin
          mismatch_count++;
          $display("%0t: end_of_stream expected %b actual %b", $time, want.eos, got.eos);
        end
      end
    end
  end

  // watchdog on cycles without any beat
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QuietLimit) begin
      $display("%0t: no beat for %0d cycles, %0d bytes still due", $time, quiet_cycles,
               packed_bytes_due.size());
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    repeat (ResetCycles) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed elements at the reset divisor of 1.0
    @(posedge clk_i);
    add_element(32'h0000_0000, 6'd0, 1'b1);   // empty end marker
    add_element(32'h0000_0000, 6'd1, 1'b0);   // zero value
    add_element(32'h4000_0000, 6'd1, 1'b0);   // exactly the divisor
    add_element(32'hc000_0000, 6'd2, 1'b0);   // minus the divisor
    add_element(32'h8000_0000, 6'd61, 1'b0);  // most negative, widest code
    add_element(32'h7fff_ffff, 6'd63, 1'b0);  // bit count above the cap
    add_element(32'h3fff_ffff, 6'd62, 1'b0);
    add_element(32'hffff_ffff, 6'd8, 1'b0);
    add_element(32'h2000_0000, 6'd5, 1'b0);   // half-way tie, rounds up
    add_element(32'he000_0000, 6'd5, 1'b0);   // negative tie
    add_element(32'h00bc_614e, 6'd0, 1'b0);   // skipped element
    add_element(32'h0000_0155, 6'd3, 1'b1);   // flush of a partial byte
    add_element(32'h0000_0000, 6'd0, 1'b1);   // marker right after a flush
    add_element(32'h2aaa_aaaa, 6'd5, 1'b1);   // byte aligned, then marker
    add_element(32'heaaa_aaab, 6'd61, 1'b1);
    add_element(32'h0000_0001, 6'd4, 1'b0);
    add_element(32'hc000_0001, 6'd7, 1'b1);
    wait_idle();

    // largest divisor
    write_max_abs(MaxAbsTop);
    queue_random_matrices(PhaseItems);
    wait_idle();

    // smallest divisor: nearly everything saturates
    write_max_abs(31'd1);
    queue_random_matrices(PhaseItems);
    wait_idle();

    // random divisor while the receiver holds off for a long stretch
    write_max_abs(31'($urandom_range(2, 32'h7fff_fffe)));
    @(posedge clk_i);
    hold_req = 1'b1;
    queue_random_matrices(PhaseItems);
    wait_idle();

    // back to 1.0
    write_max_abs(MaxAbsOne);
    queue_random_matrices(PhaseItems);
    wait_idle();

    if (mismatch_count == 0 && packed_bytes_due.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+src
src/cqbp_pkg.sv
src/cqbp_dpath.sv
src/cqbp_ctrl.sv
src/column_quantize_bit_packer.sv
tb/column_quantize_bit_packer_test.sv
